/* hw/rtl/okle_pkg.sv */
// ----------------------------------------------------------------------------
// okle_pkg
// Shared types and constants for the ordered key list engine.
// ----------------------------------------------------------------------------
package okle_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    FN_INS_FRONT = 3'd0,
    FN_INS_ORD   = 3'd1,
    FN_SEARCH    = 3'd2,
    FN_REM_FRONT = 3'd3,
    FN_REM_KEY   = 3'd4,
    FN_REVERSE   = 3'd5,
    FN_NOP6      = 3'd6,
    FN_NOP7      = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DUP    = 2'd1,
    ST_FULL   = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } fsm_t;

  // controller -> datapath
  typedef struct packed {
    logic  load;   // capture request
    logic  exec;   // compare results valid, apply operation
  } cmd_t;

endpackage

/* hw/rtl/ordered_key_list_engine.sv */
// ----------------------------------------------------------------------------
// ordered_key_list_engine
// Ordered list of up to 32 byte keys, one operation per request.
// ----------------------------------------------------------------------------
// Each request passes two steps: the key is compared against every held slot
// at once and the compare is registered, then the insert, search, remove or
// reverse is applied, any shift of the slot cells in a single step, and the
// result is registered. The result then waits in its register; a new request
// is taken in the same cycle the result is taken, and none while one is in
// flight. Slots past the held count never reach a result, so no clearing is needed after reset.
module ordered_key_list_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [2:0] func, [10:3] key, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [1:0] status, [9:2] position,
                                  // [17:10] removed_key, [26:18] entry_count
);
  import okle_pkg::*;

  cmd_t       cmd;
  logic [1:0] status;
  logic [7:0] position;
  logic [7:0] removed_key;
  logic [8:0] entry_count;

  okle_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  okle_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .func_i        (in_tdata[2:0]),
    .key_i         (in_tdata[10:3]),
    .status_o      (status),
    .position_o    (position),
    .removed_key_o (removed_key),
    .entry_count_o (entry_count)
  );

  assign out_tdata = {5'd0, entry_count, removed_key, position, status};

endmodule

/* hw/rtl/okle_datapath.sv */
// ----------------------------------------------------------------------------
// okle_datapath
// Slot cell array, parallel compare, one-step shift, result register.
// ----------------------------------------------------------------------------
module okle_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  okle_pkg::cmd_t       cmd,
  input  logic [2:0]           func_i,
  input  logic [7:0]           key_i,
  output logic [1:0]           status_o,
  output logic [7:0]           position_o,
  output logic [7:0]           removed_key_o,
  output logic [8:0]           entry_count_o
);
  import okle_pkg::*;

  logic [7:0]       slot_r [DEPTH];
  logic [7:0]       slot_nxt [DEPTH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]       func_r;
  logic [7:0]       key_r;
  logic [DEPTH-1:0] eq_r, ge_r;
  logic [1:0]       status_r, status_nxt;
  logic [7:0]       pos_r, pos_nxt;
  logic [7:0]       rem_r, rem_nxt;

  // stage one: compare every live slot
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func_i;
      key_r  <= key_i;
      for (int i = 0; i < DEPTH; i++) begin
        eq_r[i] <= (CNT_W'(i) < cnt_r) && (slot_r[i] == key_i);
        ge_r[i] <= (CNT_W'(i) < cnt_r) && (slot_r[i] >= key_i);
      end
    end
  end

  // first set bit, and whether any
  logic             eq_any, ge_any;
  logic [IDX_W-1:0] eq_idx, ge_idx;
  always_comb begin
    eq_any = 1'b0;
    ge_any = 1'b0;
    eq_idx = '0;
    ge_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (eq_r[i]) begin
        eq_any = 1'b1;
        eq_idx = IDX_W'(i);
      end
      if (ge_r[i]) begin
        ge_any = 1'b1;
        ge_idx = IDX_W'(i);
      end
    end
  end

  logic             full;
  logic [CNT_W-1:0] ins_at;
  logic [CNT_W-1:0] last;
  assign full   = (cnt_r == CNT_W'(DEPTH));
  assign ins_at = ge_any ? CNT_W'(ge_idx) : cnt_r;
  assign last   = cnt_r - CNT_W'(1);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) slot_nxt[i] = slot_r[i];
    cnt_nxt    = cnt_r;
    status_nxt = ST_OK;
    pos_nxt    = '0;
    rem_nxt    = '0;
    unique case (func_t'(func_r))
      FN_INS_FRONT: begin
        if (eq_any) begin
          status_nxt = ST_DUP;
          pos_nxt    = 8'(eq_idx);
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          for (int i = 1; i < DEPTH; i++) slot_nxt[i] = slot_r[i-1];
          slot_nxt[0] = key_r;
          cnt_nxt     = cnt_r + CNT_W'(1);
        end
      end
      FN_INS_ORD: begin
        if (ge_any && eq_r[ge_idx]) begin
          status_nxt = ST_DUP;
          pos_nxt    = 8'(ge_idx);
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (CNT_W'(i) == ins_at) slot_nxt[i] = key_r;
            else if (CNT_W'(i) > ins_at && i > 0) slot_nxt[i] = slot_r[i-1];
          end
          cnt_nxt = cnt_r + CNT_W'(1);
          pos_nxt = 8'(ins_at);
        end
      end
      FN_SEARCH: begin
        if (eq_any) pos_nxt = 8'(eq_idx);
        else status_nxt = ST_ABSENT;
      end
      FN_REM_FRONT: begin
        if (cnt_r == '0) begin
          status_nxt = ST_ABSENT;
        end else begin
          rem_nxt = slot_r[0];
          for (int i = 0; i < DEPTH - 1; i++) slot_nxt[i] = slot_r[i+1];
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      FN_REM_KEY: begin
        if (eq_any) begin
          pos_nxt = 8'(eq_idx);
          for (int i = 0; i < DEPTH - 1; i++)
            if (IDX_W'(i) >= eq_idx) slot_nxt[i] = slot_r[i+1];
          cnt_nxt = cnt_r - CNT_W'(1);
        end else begin
          status_nxt = ST_ABSENT;
        end
      end
      FN_REVERSE: begin
        // slot i takes slot (cnt-1-i) for live slots
        for (int i = 0; i < DEPTH; i++)
          if (CNT_W'(i) < cnt_r) slot_nxt[i] = slot_r[IDX_W'(last - CNT_W'(i))];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) slot_r[i] <= slot_nxt[i];
      status_r <= status_nxt;
      pos_r    <= pos_nxt;
      rem_r    <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.exec) begin
      cnt_r <= cnt_nxt;
    end
  end

  assign status_o      = status_r;
  assign position_o    = pos_r;
  assign removed_key_o = rem_r;
  assign entry_count_o = 9'(cnt_r);

endmodule

/* hw/rtl/okle_ctrl.sv */
// ----------------------------------------------------------------------------
// okle_ctrl
// Sequencer: accept, execute, hold result until taken.
// ----------------------------------------------------------------------------
module okle_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output okle_pkg::cmd_t cmd
);
  import okle_pkg::*;

  fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_tvalid = 1'b1;
        in_tready  = out_tready;
        if (out_tready) begin
          if (in_tvalid) begin
            cmd.load  = 1'b1;
            state_nxt = S_EXEC;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* sim/ordered_key_list_engine_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_key_list_engine_tb
// Drives insert, search, remove and reverse requests into the key list engine
// and checks every result against a behavioural copy of the ordered list.
// ----------------------------------------------------------------------------
module ordered_key_list_engine_tb;
  import okle_pkg::*;

  typedef struct packed {
    logic [8:0] count;
    logic [7:0] removed;
    logic [7:0] pos;
    logic [1:0] status;
  } list_result_t;

  // Behavioural list plus queue of results still owed by the engine
  class key_list_scoreboard;
    logic [7:0]   slots[$];
    list_result_t owed[$];
    int           errors;

    function int find_key(logic [7:0] k);
      foreach (slots[i]) if (slots[i] == k) return i;
      return -1;
    endfunction

    function void note_request(func_t fn, logic [7:0] k);
      list_result_t r;
      int           f;
      int           i;
      logic [7:0]   rev[$];
      r = '0;
      case (fn)
        FN_INS_FRONT: begin
          f = find_key(k);
          if (f >= 0) begin
            r.status = ST_DUP; r.pos = f[7:0];
          end else if (slots.size() >= DEPTH) r.status = ST_FULL;
          else slots.push_front(k);
        end
        FN_INS_ORD: begin
          // walk stops at first key not below k, even on an unordered list
          for (i = 0; i < slots.size(); i++) if (slots[i] >= k) break;
          if (i < slots.size() && slots[i] == k) begin
            r.status = ST_DUP; r.pos = i[7:0];
          end else if (slots.size() >= DEPTH) r.status = ST_FULL;
          else begin
            slots.insert(i, k); r.pos = i[7:0];
          end
        end
        FN_SEARCH: begin
          f = find_key(k);
          if (f >= 0) r.pos = f[7:0]; else r.status = ST_ABSENT;
        end
        FN_REM_FRONT: begin
          if (slots.size() == 0) r.status = ST_ABSENT;
          else r.removed = slots.pop_front();
        end
        FN_REM_KEY: begin
          f = find_key(k);
          if (f >= 0) begin
            r.pos = f[7:0]; slots.delete(f);
          end else r.status = ST_ABSENT;
        end
        FN_REVERSE: begin
          foreach (slots[j]) rev.push_front(slots[j]);
          slots = rev;
        end
        default: ;
      endcase
      r.count = 9'(slots.size());
      owed.push_back(r);
    endfunction

    function void check_result(list_result_t got);
      list_result_t e;
      if (owed.size() == 0) begin
        $error("unexpected result %h", got); errors++; return;
      end
      e = owed.pop_front();
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); errors++;
      end
      if (got.pos !== e.pos) begin
        $error("position exp %0d got %0d", e.pos, got.pos); errors++;
      end
      if (got.removed !== e.removed) begin
        $error("removed_key exp %0d got %0d", e.removed, got.removed); errors++;
      end
      if (got.count !== e.count) begin
        $error("entry_count exp %0d got %0d", e.count, got.count); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [2:0] func, [10:3] key, rest zero
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [1:0] status, [9:2] position,
                           // [17:10] removed_key, [26:18] entry_count

  key_list_scoreboard sb;

  ordered_key_list_engine u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Send one request: idle gap, present at falling edge, wait for handshake.
  // Valid stays up after the handshake until the next call or a drain,
  // both of which run at the very next falling edge.
  task automatic send_request(func_t fn, logic [7:0] k, bit gaps = 1'b1);
    int n;
    n = gaps ? $urandom_range(0, 6) : 0;
    if (n != 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, k, fn};
    do @(posedge clk); while (!in_tready);
    sb.note_request(fn, k);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(negedge clk);
  endtask

  // Random request biased towards keys held, so hits are common
  task automatic random_request(int key_span);
    func_t      fn;
    logic [7:0] k;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) fn = FN_INS_ORD;
    else if (pick < 45) fn = FN_INS_FRONT;
    else if (pick < 60) fn = FN_SEARCH;
    else if (pick < 72) fn = FN_REM_FRONT;
    else if (pick < 86) fn = FN_REM_KEY;
    else if (pick < 94) fn = FN_REVERSE;
    else fn = func_t'($urandom_range(6, 7));
    if (sb.slots.size() != 0 && $urandom_range(0, 1))
      k = sb.slots[$urandom_range(0, sb.slots.size() - 1)];
    else k = 8'($urandom_range(0, key_span));
    send_request(fn, k);
  endtask

  // Result side: random stall per result, with stall-free stretches
  initial begin
    int  n;
    bit  no_stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      no_stall = ($urandom_range(0, 9) < 2);
      repeat (40) begin
        n = no_stall ? 0 : $urandom_range(0, 6);
        @(negedge clk);
        if (n != 0) begin
          out_tready <= 1'b0;
          repeat (n) @(negedge clk);
        end
        out_tready <= 1'b1;
        do @(posedge clk); while (!out_tvalid);
        sb.check_result(out_tdata[26:0]);
      end
    end
  end

  initial begin
    int i;
    sb = new();
    in_tvalid = 1'b0;
    in_tdata  = '0;
    rst_n     = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty-list cases, extremes, duplicates, reverse edge cases
    send_request(FN_REM_FRONT, 8'h00);
    send_request(FN_SEARCH, 8'hFF);
    send_request(FN_REM_KEY, 8'h55);
    send_request(FN_REVERSE, 8'h00);
    send_request(FN_INS_ORD, 8'h80);
    send_request(FN_REVERSE, 8'h00);     // one key stays as it is
    send_request(FN_INS_ORD, 8'h00);
    send_request(FN_INS_ORD, 8'hFF);
    send_request(FN_INS_FRONT, 8'h80);   // duplicate at insert front
    send_request(FN_INS_ORD, 8'hFF);     // duplicate while ordered walk
    send_request(FN_INS_FRONT, 8'h7F);   // breaks order
    send_request(FN_SEARCH, 8'hFF);
    send_request(FN_REVERSE, 8'h00);
    send_request(FN_INS_ORD, 8'h90);     // walk on an unordered list
    send_request(FN_REM_KEY, 8'hFF);     // removing a key by value, not at the front
    send_request(FN_REM_FRONT, 8'h00);
    send_request(FN_NOP6, 8'hAA);
    send_request(FN_NOP7, 8'h55);
    // Fill to full, then hit full on both inserts, duplicate first
    for (i = 0; sb.slots.size() < DEPTH; i++)
      send_request(FN_INS_FRONT, 8'(i * 7 + 1), 1'b0);
    send_request(FN_INS_FRONT, 8'hFE);
    send_request(FN_INS_ORD, 8'hFD);
    send_request(FN_INS_ORD, sb.slots[DEPTH - 1]);
    send_request(FN_INS_FRONT, sb.slots[3]);
    send_request(FN_REVERSE, 8'h00);     // full-length reverse

    // Hold off until every owed result is back
    wait_drained();

    for (i = 0; i < 1200; i++) random_request(i < 600 ? 63 : 255);

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/okle_pkg.sv
hw/rtl/okle_datapath.sv
hw/rtl/okle_ctrl.sv
hw/rtl/ordered_key_list_engine.sv
sim/ordered_key_list_engine_tb.sv
